>>> rtl/free_list_heap_allocator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the free list heap allocator
// Shared checks, sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_HEAP_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_HEAP_ALLOCATOR_DEFINES_SVH

// Condition implies consequence in the same cycle
`define FLA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle
`define FLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// Types and fixed constants of the free list heap allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int BLOCK_BASE     = 8;
  localparam int META_BYTES     = 28;
  localparam int PAYLOAD_OFFSET = 24;
  localparam int ALIGN_BYTES    = 16;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OOM     = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_GROW,
    ST_FIT,
    ST_TAG,
    ST_PUSH1,
    ST_PUSH2,
    ST_F_HDR,
    ST_F_LFTR,
    ST_F_LHDR,
    ST_F_RIGHT,
    ST_F_RHDR,
    ST_F_CLAMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [16:0] granted_size;
    logic [15:0] granted_address;
  } result_t;

endpackage

>>> rtl/free_list_heap_allocator.sv
// ----------------------------------------------------------------------------
// free_list_heap_allocator
// First fit allocator over one LIFO explicit free list, with boundary tag
// coalescing on free. Block metadata lives in RAMs with registered reads.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields
// s_*      in   tuser: kind; tdata: request_size, release_address
// m_*      out  tdata: granted_address, granted_size, status
//
// Allocate walks the free list from its head, grows the heap when no entry
// fits, and tags and pushes a remainder when one is split; out of memory ends
// right after the growth check. The list walk reads the header and link RAMs
// for each entry visited. Free checks the address, reads the block header and
// up to three neighbor boundary tags, clamps, writes the tags and pushes.
// Reset clears only the state, list and heap registers; metadata RAMs are not cleared.
// A new request is taken once the previous result sits in the output register;
// a stalled output holds the engine in its final state.
// ----------------------------------------------------------------------------
`include "free_list_heap_allocator_defines.svh"

module free_list_heap_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // request_size, release_address
  input  logic        s_tuser,    // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata     // granted_address, granted_size, status, zero pad
);

  // HEAP_BYTES is taken as a power of two so slot indexes wrap by truncation
  localparam int AW    = $clog2(HEAP_BYTES) + 1;
  localparam int SLOTS = HEAP_BYTES / fla_pkg::ALIGN_BYTES;
  localparam int SW    = $clog2(SLOTS);
  localparam int SUMW  = (AW > 17 ? AW : 17) + 1;
  localparam int CW    = SW + 1;

  function automatic logic [SW-1:0] slot_of(input logic [SUMW-1:0] a);
    logic [SUMW-1:0] off;
    off = (a >= SUMW'(fla_pkg::BLOCK_BASE)) ? a - SUMW'(fla_pkg::BLOCK_BASE) : '0;
    return off[SW+3:4];
  endfunction

  function automatic logic [AW-1:0] size_of(input logic [AW-1:0] tag);
    return {tag[AW-1:4], 4'b0};
  endfunction

  function automatic logic [SUMW-1:0] ext(input logic [AW-1:0] v);
    return SUMW'(v);
  endfunction

  // metadata RAMs
  logic [AW-1:0] hdr_mem [SLOTS];
  logic [AW-1:0] ftr_mem [SLOTS];
  logic [AW-1:0] prv_mem [SLOTS];
  logic [AW-1:0] nxt_mem [SLOTS];

  logic [SW-1:0] rd_slot, ftr_rd_slot;
  logic [AW-1:0] hdr_rd, ftr_rd, prv_rd, nxt_rd;
  logic          hdr_we, ftr_we, prv_we, nxt_we;
  logic [SW-1:0] hdr_wa, ftr_wa, prv_wa, nxt_wa;
  logic [AW-1:0] hdr_wd, ftr_wd, prv_wd, nxt_wd;

  always_ff @(posedge clk) begin
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    if (ftr_we) ftr_mem[ftr_wa] <= ftr_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    hdr_rd <= hdr_mem[rd_slot];
    prv_rd <= prv_mem[rd_slot];
    nxt_rd <= nxt_mem[rd_slot];
    ftr_rd <= ftr_mem[ftr_rd_slot];
  end

  fla_pkg::state_t state, state_next;

  logic [AW-1:0]   head, head_next, tail, tail_next;
  logic [AW-1:0]   first_blk, first_blk_next, last_blk, last_blk_next;
  logic [AW-1:0]   top, top_next;
  logic            kind, kind_next;
  logic [16:0]     need, need_next;
  logic [AW-1:0]   cur, cur_next, blk, blk_next, found, found_next;
  logic [CW-1:0]   steps, steps_next;
  logic [AW-1:0]   fsize, fsize_next, co, co_next, lft, lft_next;
  logic [SUMW-1:0] total, total_next;
  logic [AW-1:0]   tb, tb_next, tsz, tsz_next, pb, pb_next, old, old_next;
  logic            tused, tused_next;
  fla_pkg::result_t res, res_next;

  logic        can_load, out_load;
  logic [15:0] in_req, in_rel;
  logic [SUMW-1:0] in_blk, right;
  logic [AW-1:0]   rd_size;
  logic        in_bad, walk_fit, walk_stop, grow_ok, split;
  logic        hdr_ok, left_go, lftr_ok, right_go;

  assign in_req  = s_tdata[15:0];
  assign in_rel  = s_tdata[31:16];
  assign in_blk  = SUMW'(in_rel) - SUMW'(fla_pkg::PAYLOAD_OFFSET);
  assign rd_size = size_of(hdr_rd);
  assign right   = ext(blk) + ext(fsize);

  // shared decisions
  always_comb begin
    in_bad    = (in_rel < 16'(fla_pkg::BLOCK_BASE + fla_pkg::PAYLOAD_OFFSET))
             || (in_rel[3:0] != 4'd0) || (in_blk >= ext(top));
    walk_fit  = SUMW'(need) <= ext(rd_size);
    walk_stop = (nxt_rd == '0) || ((steps + CW'(1)) == CW'(SLOTS));
    grow_ok   = (ext(top) + SUMW'(need)) <= SUMW'(HEAP_BYTES);
    split     = (ext(found) - SUMW'(need)) > SUMW'(fla_pkg::META_BYTES);
    hdr_ok    = hdr_rd[0] && (rd_size != '0) && (ext(rd_size) <= ext(top) - ext(blk));
    left_go   = (blk != first_blk)
             && (ext(blk) >= SUMW'(fla_pkg::BLOCK_BASE + fla_pkg::ALIGN_BYTES));
    lftr_ok   = (size_of(ftr_rd) != '0)
             && (ext(size_of(ftr_rd)) <= ext(blk) - SUMW'(fla_pkg::BLOCK_BASE));
    right_go  = (blk != last_blk) && (right < ext(top));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fla_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == fla_pkg::KIND_ALLOC) begin
            state_next = (head == '0) ? fla_pkg::ST_GROW : fla_pkg::ST_WALK;
          end else begin
            state_next = in_bad ? fla_pkg::ST_DONE : fla_pkg::ST_F_HDR;
          end
        end
      end
      fla_pkg::ST_WALK: begin
        if (walk_fit) state_next = fla_pkg::ST_FIT;
        else if (walk_stop) state_next = fla_pkg::ST_GROW;
      end
      fla_pkg::ST_GROW:    state_next = grow_ok ? fla_pkg::ST_FIT : fla_pkg::ST_DONE;
      fla_pkg::ST_FIT:     state_next = fla_pkg::ST_TAG;
      fla_pkg::ST_TAG:     state_next = tused ? fla_pkg::ST_DONE : fla_pkg::ST_PUSH1;
      fla_pkg::ST_PUSH1:   state_next = fla_pkg::ST_PUSH2;
      fla_pkg::ST_PUSH2: begin
        state_next = (kind == fla_pkg::KIND_ALLOC) ? fla_pkg::ST_TAG : fla_pkg::ST_DONE;
      end
      fla_pkg::ST_F_HDR: begin
        if (!hdr_ok) state_next = fla_pkg::ST_DONE;
        else state_next = left_go ? fla_pkg::ST_F_LFTR : fla_pkg::ST_F_RIGHT;
      end
      fla_pkg::ST_F_LFTR:  state_next = lftr_ok ? fla_pkg::ST_F_LHDR : fla_pkg::ST_F_RIGHT;
      fla_pkg::ST_F_LHDR:  state_next = fla_pkg::ST_F_RIGHT;
      fla_pkg::ST_F_RIGHT: state_next = right_go ? fla_pkg::ST_F_RHDR : fla_pkg::ST_F_CLAMP;
      fla_pkg::ST_F_RHDR:  state_next = fla_pkg::ST_F_CLAMP;
      fla_pkg::ST_F_CLAMP: state_next = fla_pkg::ST_TAG;
      fla_pkg::ST_DONE:    state_next = can_load ? fla_pkg::ST_IDLE : fla_pkg::ST_DONE;
      default:             state_next = fla_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    logic [SUMW-1:0] sum;
    logic [SUMW-1:0] clamp;
    logic            detach;
    sum    = '0;
    clamp  = '0;
    detach = 1'b0;

    s_tready    = 1'b0;
    out_load    = 1'b0;
    rd_slot     = slot_of(ext(cur));
    ftr_rd_slot = slot_of(ext(blk) - SUMW'(fla_pkg::ALIGN_BYTES));
    hdr_we = 1'b0; hdr_wa = slot_of(ext(tb)); hdr_wd = tsz | AW'(tused);
    ftr_we = 1'b0;
    ftr_wa = slot_of(ext(tb) + ext(tsz) - SUMW'(fla_pkg::ALIGN_BYTES));
    ftr_wd = tsz | AW'(tused);
    prv_we = 1'b0; prv_wa = slot_of(ext(pb)); prv_wd = '0;
    nxt_we = 1'b0; nxt_wa = slot_of(ext(pb)); nxt_wd = head;

    head_next = head; tail_next = tail; first_blk_next = first_blk;
    last_blk_next = last_blk; top_next = top; kind_next = kind; need_next = need;
    cur_next = cur; blk_next = blk; found_next = found; steps_next = steps;
    fsize_next = fsize; co_next = co; lft_next = lft; total_next = total;
    tb_next = tb; tsz_next = tsz; tused_next = tused; pb_next = pb; old_next = old;
    res_next = res;

    unique case (state)
      fla_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        kind_next  = s_tuser;
        need_next  = (17'(in_req) + 17'(fla_pkg::META_BYTES + fla_pkg::ALIGN_BYTES - 1))
                   & ~17'(fla_pkg::ALIGN_BYTES - 1);
        cur_next   = head;
        steps_next = '0;
        blk_next   = AW'(in_blk);
        rd_slot    = (s_tuser == fla_pkg::KIND_ALLOC) ? slot_of(ext(head)) : slot_of(in_blk);
        res_next.granted_address = '0;
        res_next.granted_size    = '0;
        res_next.status          = fla_pkg::STATUS_IGNORED;
      end
      fla_pkg::ST_WALK: begin
        if (walk_fit) begin
          blk_next   = cur;
          found_next = rd_size;
          detach     = 1'b1;
        end else begin
          cur_next   = nxt_rd;
          steps_next = steps + CW'(1);
          rd_slot    = slot_of(ext(nxt_rd));
        end
      end
      fla_pkg::ST_GROW: begin
        if (grow_ok) begin
          sum        = ext(top) + SUMW'(need);
          blk_next   = top;
          top_next   = AW'(sum);
          found_next = AW'(need);
          last_blk_next = top;
          if (first_blk == '0) first_blk_next = top;
        end else begin
          res_next.status = fla_pkg::STATUS_OOM;
        end
      end
      fla_pkg::ST_FIT: begin
        sum = ext(blk) + SUMW'(fla_pkg::PAYLOAD_OFFSET);
        res_next.granted_address = sum[15:0];
        res_next.status          = fla_pkg::STATUS_OK;
        if (split) begin
          sum        = ext(blk) + SUMW'(need);
          tb_next    = AW'(sum);
          tsz_next   = AW'(ext(found) - SUMW'(need));
          tused_next = 1'b0;
          if (sum > ext(last_blk)) last_blk_next = AW'(sum);
          res_next.granted_size = 17'(need);
        end else begin
          tb_next    = blk;
          tsz_next   = found;
          tused_next = 1'b1;
          clamp      = ext(found);
          res_next.granted_size = clamp[16:0];
        end
      end
      fla_pkg::ST_TAG: begin
        hdr_we  = 1'b1;
        ftr_we  = 1'b1;
        pb_next = tb;
      end
      fla_pkg::ST_PUSH1: begin
        prv_we    = 1'b1;
        nxt_we    = 1'b1;
        old_next  = head;
        head_next = pb;
        if (head == '0) tail_next = pb;
      end
      fla_pkg::ST_PUSH2: begin
        prv_wa = slot_of(ext(old));
        prv_wd = pb;
        prv_we = (old != '0);
        tb_next    = blk;
        tsz_next   = AW'(need);
        tused_next = 1'b1;
      end
      fla_pkg::ST_F_HDR: begin
        fsize_next = rd_size;
        total_next = ext(rd_size);
        co_next    = blk;
      end
      fla_pkg::ST_F_LFTR: begin
        lft_next = AW'(ext(blk) - ext(size_of(ftr_rd)));
        rd_slot  = slot_of(ext(blk) - ext(size_of(ftr_rd)));
      end
      fla_pkg::ST_F_LHDR: begin
        if (!hdr_rd[0]) begin
          detach     = 1'b1;
          total_next = total + ext(rd_size);
          co_next    = lft;
        end
      end
      fla_pkg::ST_F_RIGHT: begin
        rd_slot = slot_of(right);
        if (blk == last_blk) last_blk_next = co;
      end
      fla_pkg::ST_F_RHDR: begin
        if (!hdr_rd[0]) begin
          detach     = 1'b1;
          total_next = total + ext(rd_size);
          if (right == ext(last_blk)) last_blk_next = co;
        end
      end
      fla_pkg::ST_F_CLAMP: begin
        clamp = (total > ext(top) - ext(co)) ? ext(top) - ext(co) : total;
        tb_next    = co;
        tsz_next   = AW'(clamp);
        tused_next = 1'b0;
        res_next.granted_size = clamp[16:0];
        res_next.status       = fla_pkg::STATUS_OK;
      end
      fla_pkg::ST_DONE: begin
        out_load = can_load;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase

    // unlink the block whose links were just read
    if (detach) begin
      if (prv_rd == '0) begin
        head_next = nxt_rd;
      end else begin
        nxt_we = 1'b1;
        nxt_wa = slot_of(ext(prv_rd));
        nxt_wd = nxt_rd;
      end
      if (nxt_rd == '0) begin
        tail_next = prv_rd;
      end else begin
        prv_we = 1'b1;
        prv_wa = slot_of(ext(nxt_rd));
        prv_wd = prv_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fla_pkg::ST_IDLE;
      head      <= '0;
      tail      <= '0;
      first_blk <= '0;
      last_blk  <= '0;
      top       <= AW'(fla_pkg::BLOCK_BASE);
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      first_blk <= first_blk_next;
      last_blk  <= last_blk_next;
      top       <= top_next;
    end
  end

  always_ff @(posedge clk) begin
    kind  <= kind_next;  need  <= need_next;  cur   <= cur_next;
    blk   <= blk_next;   found <= found_next; steps <= steps_next;
    fsize <= fsize_next; co    <= co_next;    lft   <= lft_next;
    total <= total_next; tb    <= tb_next;    tsz   <= tsz_next;
    tused <= tused_next; pb    <= pb_next;    old   <= old_next;
    res   <= res_next;
  end

  fla_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_data (res),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  `FLA_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state != fla_pkg::ST_IDLE, "accepted transaction left engine idle")
  `FLA_ASSERT_NOW(a_top_bounded, 1'b1, ext(top) <= SUMW'(HEAP_BYTES), "heap top past heap end")
  `FLA_ASSERT_NOW(a_top_aligned, 1'b1, top[3:0] == 4'(fla_pkg::BLOCK_BASE), "heap top off block alignment")
  `FLA_ASSERT_NEXT(a_done_returns, state == fla_pkg::ST_DONE && can_load, state == fla_pkg::ST_IDLE && m_tvalid, "result not handed to output register")

endmodule

>>> rtl/fla_out_reg.sv
// ----------------------------------------------------------------------------
// fla_out_reg
// Result register on the master side; holds a result until it is taken.
// ----------------------------------------------------------------------------
module fla_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  fla_pkg::result_t  load_data,
  output logic              can_load,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata    // granted_address, granted_size, status, zero pad
);

  fla_pkg::result_t data;

  assign can_load = !m_tvalid || m_tready;
  assign m_tdata  = {5'b0, data.status, data.granted_size, data.granted_address};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

>>> dv/free_list_heap_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// free_list_heap_allocator_tb
// Drives directed, then random allocate and free requests in bursts against a
// stalling receiver. A scoreboard keeps its own copy of the heap tags, links
// and registers, predicts every result, and compares each result field by field.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_tb;

  localparam int HEAP   = 65536;
  localparam int ALIGN  = fla_pkg::ALIGN_BYTES;
  localparam int BASE   = fla_pkg::BLOCK_BASE;
  localparam int POFF   = fla_pkg::PAYLOAD_OFFSET;
  localparam int SLOTS  = HEAP / ALIGN;

  class heap_scoreboard;
    int unsigned hdr[SLOTS];
    int unsigned ftr[SLOTS];
    int unsigned lprev[SLOTS];
    int unsigned lnext[SLOTS];
    bit          hdr_seen[SLOTS];
    bit          ftr_seen[SLOTS];
    int unsigned head, tail, first_b, last_b, top;
    fla_pkg::result_t pending[$];
    int          mismatches;

    function new();
      head = 0; tail = 0; first_b = 0; last_b = 0; top = BASE;
      mismatches = 0;
    endfunction

    function int unsigned idx(int unsigned a);
      int unsigned off;
      off = (a >= BASE) ? a - BASE : 0;
      return (off / ALIGN) % SLOTS;
    endfunction

    function int unsigned bytes(int unsigned tag);
      return tag & ~(ALIGN - 1);
    endfunction

    function void put_tags(int unsigned b, int unsigned sz, int unsigned used);
      hdr[idx(b)] = sz | used;
      hdr_seen[idx(b)] = 1;
      ftr[idx(b + sz - ALIGN)] = sz | used;
      ftr_seen[idx(b + sz - ALIGN)] = 1;
    endfunction

    function void unlink(int unsigned b);
      int unsigned p, n;
      p = lprev[idx(b)];
      n = lnext[idx(b)];
      if (p == 0) head = n; else lnext[idx(p)] = n;
      if (n == 0) tail = p; else lprev[idx(n)] = p;
    endfunction

    function void push_head(int unsigned b);
      int unsigned old;
      old = head;
      lprev[idx(b)] = 0;
      lnext[idx(b)] = old;
      head = b;
      if (old == 0) tail = b; else lprev[idx(old)] = b;
    endfunction

    function fla_pkg::result_t alloc(int unsigned req);
      fla_pkg::result_t r;
      int unsigned need, blk, found, steps, cur, sz, asz, rem;
      need = (req + fla_pkg::META_BYTES + ALIGN - 1) / ALIGN * ALIGN;
      blk = 0; found = 0; steps = 0; cur = head;
      while (cur != 0 && steps < SLOTS) begin
        sz = bytes(hdr[idx(cur)]);
        if (need <= sz) begin
          blk = cur; found = sz;
          break;
        end
        cur = lnext[idx(cur)];
        steps++;
      end
      if (blk != 0) begin
        unlink(blk);
      end else begin
        if (top + need > HEAP) begin
          r.granted_address = 0; r.granted_size = 0; r.status = fla_pkg::STATUS_OOM;
          return r;
        end
        blk = top;
        top += need;
        if (first_b == 0) first_b = blk;
        last_b = blk;
        found = need;
      end
      if (found - need > fla_pkg::META_BYTES) begin
        rem = blk + need;
        put_tags(rem, found - need, 0);
        push_head(rem);
        if (rem > last_b) last_b = rem;
        asz = need;
      end else begin
        asz = found;
      end
      put_tags(blk, asz, 1);
      r.granted_address = 16'(blk + POFF);
      r.granted_size = 17'(asz);
      r.status = fla_pkg::STATUS_OK;
      return r;
    endfunction

    function fla_pkg::result_t release_block(int unsigned a);
      fla_pkg::result_t r;
      int unsigned blk, tag, sz, total, co, lsz, left, ltag, right, rtag;
      r.granted_address = 0; r.granted_size = 0; r.status = fla_pkg::STATUS_IGNORED;
      if (a < BASE + POFF) return r;
      blk = a - POFF;
      if ((blk - BASE) % ALIGN != 0 || blk >= top) return r;
      tag = hdr[idx(blk)];
      sz = bytes(tag);
      if (!tag[0] || sz == 0 || sz > top - blk) return r;
      total = sz;
      co = blk;
      if (blk != first_b && blk >= BASE + ALIGN) begin
        lsz = bytes(ftr[idx(blk - ALIGN)]);
        if (lsz != 0 && lsz <= blk - BASE) begin
          left = blk - lsz;
          ltag = hdr[idx(left)];
          if (!ltag[0]) begin
            unlink(left);
            total += bytes(ltag);
            co = left;
          end
        end
      end
      if (blk != last_b) begin
        right = blk + sz;
        if (right < top) begin
          rtag = hdr[idx(right)];
          if (!rtag[0]) begin
            unlink(right);
            total += bytes(rtag);
            if (right == last_b) last_b = co;
          end
        end
      end else begin
        last_b = co;
      end
      if (total > top - co) total = top - co;
      put_tags(co, total, 0);
      push_head(co);
      r.granted_size = 17'(total);
      r.status = fla_pkg::STATUS_OK;
      return r;
    endfunction

    // True when a free of this address only touches tag entries written before.
    function bit free_is_safe(int unsigned a);
      int unsigned blk, tag, sz, lsz;
      if (a < BASE + POFF) return 1;
      blk = a - POFF;
      if ((blk - BASE) % ALIGN != 0 || blk >= top) return 1;
      if (!hdr_seen[idx(blk)]) return 0;
      tag = hdr[idx(blk)];
      sz = bytes(tag);
      if (!tag[0] || sz == 0 || sz > top - blk) return 1;
      if (blk != first_b && blk >= BASE + ALIGN) begin
        if (!ftr_seen[idx(blk - ALIGN)]) return 0;
        lsz = bytes(ftr[idx(blk - ALIGN)]);
        if (lsz != 0 && lsz <= blk - BASE && !hdr_seen[idx(blk - lsz)]) return 0;
      end
      if (blk != last_b && blk + sz < top && !hdr_seen[idx(blk + sz)]) return 0;
      return 1;
    endfunction

    function fla_pkg::result_t note_input(logic kind, logic [15:0] req, logic [15:0] addr);
      fla_pkg::result_t r;
      if (kind == fla_pkg::KIND_ALLOC) r = alloc(req);
      else r = release_block(addr);
      pending.push_back(r);
      return r;
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check(fla_pkg::result_t got);
      fla_pkg::result_t want;
      if (pending.size() == 0) begin
        report("unexpected result, status", got.status, 0);
        return;
      end
      want = pending.pop_front();
      if (got.granted_address !== want.granted_address)
        report("granted_address", got.granted_address, want.granted_address);
      if (got.granted_size !== want.granted_size)
        report("granted_size", got.granted_size, want.granted_size);
      if (got.status !== want.status)
        report("status", got.status, want.status);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;    // request_size, release_address
  logic        s_tuser;    // kind
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;    // granted_address, granted_size, status, zero pad

  free_list_heap_allocator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  heap_scoreboard sb = new();
  logic [15:0]    live[$];
  logic [15:0]    history[$];
  int             burst_left;
  int unsigned    cyc;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("free_list_heap_allocator_tb NOT OK");
    $finish;
  end

  // Receiver stall pattern, stepping through four ready patterns in turn.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case ((cyc >> 6) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(1));
      2: m_tready <= ($urandom_range(3) == 0);
      default: m_tready <= (cyc % 3 == 0);
    endcase
  end

  always @(negedge clk) begin
    fla_pkg::result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.granted_address = m_tdata[15:0];
      got.granted_size = m_tdata[32:16];
      got.status = m_tdata[34:33];
      sb.check(got);
    end
  end

  task send_request(logic kind, logic [15:0] req, logic [15:0] addr);
    bit      took;
    fla_pkg::result_t r;
    int      gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {addr, req};
    took = 0;
    while (!took) begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end
    r = sb.note_input(kind, req, addr);
    if (kind == fla_pkg::KIND_ALLOC && r.status == fla_pkg::STATUS_OK) begin
      live.push_back(r.granted_address);
      history.push_back(r.granted_address);
    end
  endtask

  task free_live(int i);
    logic [15:0] a;
    a = live[i];
    live.delete(i);
    send_request(fla_pkg::KIND_FREE, 16'($urandom), a);
  endtask

  initial begin
    int          r, n;
    logic [15:0] a;
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = 0;
    m_tready = 0;
    cyc = 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, null and bad frees, coalescing, split, growth limit.
    send_request(fla_pkg::KIND_ALLOC, 16'd0, 16'hffff);
    send_request(fla_pkg::KIND_ALLOC, 16'hffff, 16'd0);
    send_request(fla_pkg::KIND_FREE, 16'hffff, 16'd0);
    send_request(fla_pkg::KIND_FREE, 16'd0, 16'd5);
    send_request(fla_pkg::KIND_FREE, 16'd0, 16'd33);
    send_request(fla_pkg::KIND_FREE, 16'd0, 16'hffff);
    send_request(fla_pkg::KIND_ALLOC, 16'd100, 16'd0);
    send_request(fla_pkg::KIND_ALLOC, 16'd200, 16'd0);
    send_request(fla_pkg::KIND_ALLOC, 16'd1, 16'd0);
    send_request(fla_pkg::KIND_ALLOC, 16'd300, 16'd0);
    a = live[2];
    free_live(2);                                // middle block, neighbors used
    free_live(1);                                // merge with free right neighbor
    send_request(fla_pkg::KIND_FREE, 16'd0, a);  // double free of a merged block
    free_live(live.size() - 1);                  // last block, left neighbor used
    send_request(fla_pkg::KIND_ALLOC, 16'd50, 16'd0);
    send_request(fla_pkg::KIND_ALLOC, 16'd36, 16'd0);
    send_request(fla_pkg::KIND_ALLOC, 16'd64000, 16'd0);
    send_request(fla_pkg::KIND_ALLOC, 16'd2000, 16'd0);
    free_live(live.size() - 1);
    send_request(fla_pkg::KIND_ALLOC, 16'd63000, 16'd0);
    while (live.size() > 0) free_live(0);

    for (n = 0; n < 1230; n++) begin
      r = $urandom_range(99);
      if (live.size() == 0 || r < 50) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: a = 16'($urandom_range(255));
          6, 7, 8: a = 16'($urandom_range(4095));
          default: a = 16'($urandom);
        endcase
        send_request(fla_pkg::KIND_ALLOC, a, 16'($urandom));
      end else if (r < 87) begin
        free_live($urandom_range(live.size() - 1));
      end else begin
        if (r < 93 || history.size() == 0) a = 16'($urandom);
        else a = 16'(history[$urandom_range(history.size() - 1)] + 16 * $urandom_range(2));
        if (!sb.free_is_safe(a)) a = 0;
        send_request(fla_pkg::KIND_FREE, 16'($urandom), a);
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("free_list_heap_allocator_tb OK");
    end else begin
      $display("free_list_heap_allocator_tb NOT OK");
    end
    $finish;
  end
endmodule
